/* rtl/core/wsdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parse phases, event codes and header constants for the deframer core; its
// port checker uses the widths and event codes.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned KEY_BYTES = 4;
  localparam int unsigned LEN_BITS  = 16;
  localparam int unsigned OPC_BITS  = 7;
  localparam int unsigned EV_BITS   = 2;

  localparam logic [OPC_BITS-1:0] LEN_EXT16 = 7'd126;
  localparam logic [OPC_BITS-1:0] LEN_EXT64 = 7'd127;

  // result event codes
  localparam logic [EV_BITS-1:0] EV_DATA  = 2'd0;
  localparam logic [EV_BITS-1:0] EV_EMPTY = 2'd1;
  localparam logic [EV_BITS-1:0] EV_LEN64 = 2'd2;

  typedef enum logic [5:0] {
    PH_HEAD   = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_EXT_HI = 6'b000100,
    PH_EXT_LO = 6'b001000,
    PH_KEY    = 6'b010000,
    PH_DATA   = 6'b100000
  } phase_t;

  typedef logic [KEY_BYTES-1:0][BYTE_BITS-1:0] key_t;

endpackage

/* rtl/core/websocket_frame_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Parses a received byte stream into frames: header, optional 16-bit length,
// optional mask key, then unmasked payload bytes with the last one marked.
// ----------------------------------------------------------------------------
//  channel | signals                                      | role
//  --------+----------------------------------------------+-------------------
//  in      | in_valid, in_stall, rx_byte, link_lost       | received bytes
//  out     | out_valid, out_stall, event_res, frame_opcode,| parse results
//          | payload_byte, last_of_frame                  |
//
//  One byte per cycle while in_stall is low: the parse state and the result
//  register both update in the cycle a transaction is accepted, so a result shows in the next cycle.
//  in_stall rises only while a result is held and out_stall is high.
//  Header, length and key bytes produce no result unless they close the frame.
//  rst is synchronous: it returns the parser to the header phase and
//  empties the result register.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core
  import wsdf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_BITS-1:0] rx_byte,
  input  logic                 link_lost,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [EV_BITS-1:0]   event_res,
  output logic [OPC_BITS-1:0]  frame_opcode,
  output logic [BYTE_BITS-1:0] payload_byte,
  output logic                 last_of_frame
);

  phase_t                phase, phase_next;
  logic [OPC_BITS-1:0]   opcode, opcode_next;
  logic                  masked, masked_next;
  logic [LEN_BITS-1:0]   length, length_next;
  key_t                  mask_key, mask_key_next;
  logic [LEN_BITS-1:0]   count, count_next;

  logic                  in_fire;
  logic [LEN_BITS-1:0]   count_inc;
  logic [BYTE_BITS-1:0]  key_byte;
  logic                  hdr_done;
  logic [LEN_BITS-1:0]   hdr_len;
  logic                  res_fire;
  logic [EV_BITS-1:0]    res_event;
  logic [BYTE_BITS-1:0]  res_data;
  logic                  res_last;

  assign in_stall  = out_valid & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign count_inc = count + LEN_BITS'(1);
  // key byte i arrives i-th and sits at index 3-i
  assign key_byte  = mask_key[~count[1:0]];

  always_comb begin
    phase_next    = phase;
    opcode_next   = opcode;
    masked_next   = masked;
    length_next   = length;
    mask_key_next = mask_key;
    count_next    = count;
    hdr_done      = 1'b0;
    hdr_len       = length;
    res_fire      = 1'b0;
    res_event     = EV_DATA;
    res_data      = '0;
    res_last      = 1'b0;

    if (link_lost) begin
      // drop partial frame
      phase_next = PH_HEAD;
      count_next = '0;
    end else begin
      unique case (phase)
        PH_LEN: begin
          masked_next = rx_byte[BYTE_BITS-1];
          if (rx_byte[OPC_BITS-1:0] == LEN_EXT64) begin
            phase_next = PH_HEAD;
            res_fire   = 1'b1;
            res_event  = EV_LEN64;
            res_last   = 1'b1;
          end else if (rx_byte[OPC_BITS-1:0] == LEN_EXT16) begin
            phase_next = PH_EXT_HI;
          end else begin
            hdr_len  = LEN_BITS'(rx_byte[OPC_BITS-1:0]);
            hdr_done = 1'b1;
          end
        end
        PH_EXT_HI: begin
          length_next = {rx_byte, {BYTE_BITS{1'b0}}};
          phase_next  = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          hdr_len  = {length[LEN_BITS-1:BYTE_BITS], rx_byte};
          hdr_done = 1'b1;
        end
        PH_KEY: begin
          mask_key_next[~count[1:0]] = rx_byte;
          count_next = count_inc;
          if (count[1:0] == 2'(KEY_BYTES - 1)) begin
            count_next = '0;
            if (length == '0) begin
              masked_next = 1'b0;
              phase_next  = PH_HEAD;
              res_fire    = 1'b1;
              res_event   = EV_EMPTY;
              res_last    = 1'b1;
            end else begin
              masked_next = 1'b1;
              phase_next  = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          res_fire   = 1'b1;
          res_data   = rx_byte ^ (masked ? key_byte : '0);
          res_last   = (count_inc == length);
          count_next = res_last ? '0 : count_inc;
          if (res_last) begin
            phase_next = PH_HEAD;
          end
        end
        default: begin
          opcode_next = rx_byte[OPC_BITS-1:0];
          phase_next  = PH_LEN;
        end
      endcase

      if (hdr_done) begin
        length_next = hdr_len;
        count_next  = '0;
        if (masked_next) begin
          phase_next = PH_KEY;
        end else if (hdr_len == '0) begin
          phase_next = PH_HEAD;
          res_fire   = 1'b1;
          res_event  = EV_EMPTY;
          res_last   = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEAD;
      opcode   <= '0;
      masked   <= 1'b0;
      length   <= '0;
      mask_key <= '0;
      count    <= '0;
    end else if (in_fire) begin
      phase    <= phase_next;
      opcode   <= opcode_next;
      masked   <= masked_next;
      length   <= length_next;
      mask_key <= mask_key_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_fire;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // opcode comes from the state before this byte; only the header byte changes it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_res     <= res_event;
      frame_opcode  <= opcode;
      payload_byte  <= res_data;
      last_of_frame <= res_last;
    end
  end

endmodule

/* rtl/core/wsdf_port_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the core's ports over time and is bound to every core instance.
// ----------------------------------------------------------------------------
module wsdf_port_checker
  import wsdf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 link_lost,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [EV_BITS-1:0]   event_res,
  input  logic [OPC_BITS-1:0]  frame_opcode,
  input  logic [BYTE_BITS-1:0] payload_byte,
  input  logic                 last_of_frame
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res)
      && $stable(frame_opcode) && $stable(payload_byte) && $stable(last_of_frame))
    else $error("stalled result changed");

  a_event_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_DATA |->
      last_of_frame && payload_byte == '0
      && (event_res == EV_EMPTY || event_res == EV_LEN64))
    else $error("non-data event malformed");

  a_lost_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && link_lost |=> !out_valid)
    else $error("link-lost transaction produced a result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

endmodule

bind websocket_frame_deframer_core wsdf_port_checker u_wsdf_port_checker (.*);
